// ===== src/wccp_pkg.sv =====
// Shared types, constants and helper functions for the weather condition code parser.
package wccp_pkg;

	// Most condition codes one group may hold.
	localparam int MAX_CONDS   = 4;
	localparam int CNT_W       = $clog2(MAX_CONDS + 1);
	localparam int SHOWN_SLOTS = (MAX_CONDS < 4) ? MAX_CONDS : 4;
	localparam int NUM_CODES   = 31;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Two-letter condition codes; code number is the position plus one.
	localparam logic [15:0] CODE_PAIRS [NUM_CODES] = '{
		"VC", "BC", "BL", "DR", "FZ", "MI", "PR", "SH", "TS", "DZ", "GR",
		"GS", "IC", "PL", "RA", "SG", "SN", "UP", "BR", "DU", "FG", "FU",
		"HZ", "PY", "SA", "VA", "DS", "FC", "PO", "SQ", "SS"
	};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DANGLING = 2'd1,
		ST_UNKNOWN  = 2'd2,
		ST_TOO_MANY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		INT_NONE  = 2'd0,
		INT_LIGHT = 2'd1,
		INT_HEAVY = 2'd2
	} intensity_t;

	typedef struct packed {
		logic                        at_start;
		logic                        half_pending;
		logic [7:0]                  first_letter;
		logic [CNT_W-1:0]            slot_count;
		logic [MAX_CONDS-1:0][4:0]   slot_codes;
		intensity_t                  intensity;
		status_t                     error;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		at_start:     1'b1,
		half_pending: 1'b0,
		first_letter: 8'h00,
		slot_count:   '0,
		slot_codes:   '0,
		intensity:    INT_NONE,
		error:        ST_OK
	};

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	// Returns 1..31 for a known pair and 0 for an unknown one.
	function automatic logic [4:0] code_lookup(input logic [7:0] a, input logic [7:0] b);
		logic [4:0] code;
		code = '0;
		for (int i = 0; i < NUM_CODES; i++) begin
			if (CODE_PAIRS[i] == {a, b}) begin
				code = 5'(i + 1);
			end
		end
		return code;
	endfunction

endpackage

// ===== src/wccp_if.sv =====
// Handshake channels for the parser: one character in, one parse result out.
interface wccp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface wccp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  intensity;
	logic [2:0]  code_count;
	logic [19:0] codes;

	modport source (output valid, output status, output intensity, output code_count,
		output codes, input ready);
	modport sink (input valid, input status, input intensity, input code_count,
		input codes, output ready);
endinterface

// ===== src/weather_condition_code_parser_top.sv =====
// Parser for a present-weather group that takes one character per cycle, save while a last
// character is stalled, and reports one result per group. Characters arrive on text with last
// marking the end of the group; each item passes through an input register, and the combinational
// parse step (a parallel compare against all 31 codes) updates the parse state. The result is
// registered in the output register as the last character leaves the input stage and is held
// until taken; only a last character is stalled while an untaken result is still waiting.
module weather_condition_code_parser_top
	import wccp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	wccp_char_if.sink            text,
	wccp_result_if.source        report
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         last_s1;
	logic         advance;

	parse_state_t state_q;
	parse_state_t state_nxt;
	status_t      final_status;
	logic [19:0]  packed_codes;

	logic         out_valid_q;
	logic [1:0]   status_q;
	logic [1:0]   intensity_q;
	logic [2:0]   count_q;
	logic [19:0]  codes_q;

	// The stage may move on unless it holds a last character and the result slot is still full.
	assign advance    = valid_s1 && (!last_s1 || !out_valid_q || report.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1   <= text.ch;
			last_s1 <= text.last;
		end
	end

	always_comb begin
		logic       sign;
		logic [7:0] up;
		logic [4:0] code;
		state_nxt = state_q;
		sign      = state_q.at_start && (ch_s1 == CH_PLUS || ch_s1 == CH_MINUS);
		up        = to_upper(ch_s1);
		code      = code_lookup(state_q.first_letter, up);
		if (state_q.at_start) begin
			state_nxt.at_start = 1'b0;
			if (ch_s1 == CH_PLUS) begin
				state_nxt.intensity = INT_HEAVY;
			end else if (ch_s1 == CH_MINUS) begin
				state_nxt.intensity = INT_LIGHT;
			end
		end
		if (!sign && state_q.error == ST_OK) begin
			if (!state_q.half_pending) begin
				if (state_q.slot_count >= CNT_W'(MAX_CONDS)) begin
					state_nxt.error = ST_TOO_MANY;
				end else begin
					state_nxt.first_letter = up;
					state_nxt.half_pending = 1'b1;
				end
			end else begin
				state_nxt.half_pending = 1'b0;
				if (code == 5'd0) begin
					state_nxt.error = ST_UNKNOWN;
				end else if (state_q.slot_count < CNT_W'(MAX_CONDS)) begin
					for (int i = 0; i < MAX_CONDS; i++) begin
						if (state_q.slot_count == CNT_W'(i)) begin
							state_nxt.slot_codes[i] = code;
						end
					end
					state_nxt.slot_count = state_q.slot_count + 1'b1;
				end
			end
		end
	end

	always_comb begin
		final_status = state_nxt.error;
		if (state_nxt.error == ST_OK && state_nxt.half_pending) begin
			final_status = ST_DANGLING;
		end
		packed_codes = '0;
		for (int i = 0; i < SHOWN_SLOTS; i++) begin
			packed_codes[5*i +: 5] = state_nxt.slot_codes[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= last_s1 ? STATE_RESET : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q    <= final_status;
			intensity_q <= state_nxt.intensity;
			count_q     <= 3'(state_nxt.slot_count);
			codes_q     <= packed_codes;
		end
	end

	assign report.valid      = out_valid_q;
	assign report.status     = status_q;
	assign report.intensity  = intensity_q;
	assign report.code_count = count_q;
	assign report.codes      = codes_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.slot_count <= CNT_W'(MAX_CONDS))
		else $error("slot count exceeds the slot capacity");

	a_half_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.half_pending |-> state_q.slot_count < CNT_W'(MAX_CONDS))
		else $error("pending first letter without a free slot");

	a_group_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.at_start && !state_q.half_pending)
		else $error("parse state not cleared after the end of a group");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !report.ready |-> !(advance && last_s1))
		else $error("waiting result overwritten");

	a_intensity_only_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !state_q.at_start && !last_s1 |=> $stable(state_q.intensity))
		else $error("intensity changed after the first character");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the present-weather group parser: random and directed groups.
`timescale 1ns / 1ps

module tb;
	import wccp_pkg::*;

	localparam int    WATCHDOG_LIMIT = 2000;
	localparam int    HOLD_CYCLES    = 200;
	localparam int    CHAR_TARGET    = 1000;
	localparam string PAIR_TEXT      =
		"VCBCBLDRFZMIPRSHTSDZGRGSICPLRASGSNUPBRDUFGFUHZPYSAVADSFCPOSQSS";

	typedef struct {
		status_t     status;
		intensity_t  intensity;
		logic [2:0]  count;
		logic [19:0] codes;
	} wx_report_t;

	// Tracks the parse of the current group and holds the reports still owed by the block.
	class wx_group_board;
		bit          at_start;
		bit          half_pending;
		logic [7:0]  first_letter;
		int          slot_count;
		logic [4:0]  slot_codes [MAX_CONDS];
		intensity_t  intensity;
		status_t     err;
		wx_report_t  pending_reports [$];
		int          chars_seen;
		int          reports_checked;
		int          mismatches;
		int          status_seen [4];

		function new();
			clear_group();
		endfunction

		function void clear_group();
			at_start     = 1'b1;
			half_pending = 1'b0;
			first_letter = 8'h00;
			slot_count   = 0;
			foreach (slot_codes[i]) slot_codes[i] = 5'd0;
			intensity    = INT_NONE;
			err          = ST_OK;
		endfunction

		function logic [7:0] upcase(logic [7:0] c);
			return (c >= "a" && c <= "z") ? c - 8'd32 : c;
		endfunction

		function logic [4:0] pair_code(logic [7:0] a, logic [7:0] b);
			for (int i = 0; i < NUM_CODES; i++) begin
				if (PAIR_TEXT[2*i] == a && PAIR_TEXT[2*i+1] == b) return 5'(i + 1);
			end
			return 5'd0;
		endfunction

		function void predict_char(logic [7:0] c, logic is_last);
			bit         taken;
			logic [4:0] code;
			wx_report_t r;
			taken = 1'b0;
			chars_seen++;
			if (at_start) begin
				at_start = 1'b0;
				if (c == CH_PLUS) begin
					intensity = INT_HEAVY;
					taken     = 1'b1;
				end else if (c == CH_MINUS) begin
					intensity = INT_LIGHT;
					taken     = 1'b1;
				end
			end
			if (!taken && err == ST_OK) begin
				if (!half_pending) begin
					if (slot_count >= MAX_CONDS) begin
						err = ST_TOO_MANY;
					end else begin
						first_letter = upcase(c);
						half_pending = 1'b1;
					end
				end else begin
					code         = pair_code(first_letter, upcase(c));
					half_pending = 1'b0;
					if (code == 5'd0) begin
						err = ST_UNKNOWN;
					end else if (slot_count < MAX_CONDS) begin
						slot_codes[slot_count] = code;
						slot_count++;
					end
				end
			end
			if (is_last) begin
				if (err == ST_OK && half_pending) err = ST_DANGLING;
				r.status    = err;
				r.intensity = intensity;
				r.count     = 3'(slot_count);
				r.codes     = '0;
				for (int i = 0; i < 4 && i < MAX_CONDS; i++) r.codes[5*i +: 5] = slot_codes[i];
				pending_reports.push_back(r);
				status_seen[err]++;
				clear_group();
			end
		endfunction

		function void check_report(logic [1:0] st, logic [1:0] inten, logic [2:0] cnt,
			logic [19:0] codes);
			wx_report_t e;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected report status=%0d int=%0d count=%0d codes=%05h",
						$realtime, st, inten, cnt, codes);
				return;
			end
			e = pending_reports.pop_front();
			reports_checked++;
			if (e.status !== st || e.intensity !== inten || e.count !== cnt ||
				e.codes !== codes) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: report %0d status %0d/%0d int %0d/%0d count %0d/%0d ",
						"codes %05h/%05h (exp/act)"},
						$realtime, reports_checked, e.status, st, e.intensity, inten,
						e.count, cnt, e.codes, codes);
			end
		endfunction

		function int owed();
			return pending_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wccp_char_if   text_ch ();
	wccp_result_if result_ch ();

	weather_condition_code_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.report (result_ch)
	);

	wx_group_board board = new();
	logic [7:0]    grp [$];
	bit            calm;
	bit            hold_req;
	bit            drained;
	int            holds_done;
	int            quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) board.predict_char(text_ch.ch, text_ch.last);
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_report(result_ch.status, result_ch.intensity, result_ch.code_count,
				result_ch.codes);
	end

	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $realtime, quiet_cycles);
				$display("[weather_condition_code_parser_top] ERROR");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, one long hold-off on request, none near the end.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				hold_req = 1'b0;
				holds_done++;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic offer(input logic [7:0] c, input logic is_last);
		text_ch.valid <= 1'b1;
		text_ch.ch    <= c;
		text_ch.last  <= is_last;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
	endtask

	task automatic send_group(input bit bursty);
		for (int i = 0; i < grp.size(); i++) begin
			offer(grp[i], i == grp.size() - 1);
			if (bursty && !calm && $urandom_range(0, 3) == 0) begin
				text_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
		grp.delete();
	endtask

	// The first edge lets the scoreboard see the item accepted at the current edge.
	task automatic wait_all_reports();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.owed() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) grp.push_back(s[i]);
	endfunction

	// Pushes both letters of a code, each in a random case.
	function automatic void add_code(input int code);
		logic [7:0] ltr;
		for (int k = 0; k < 2; k++) begin
			ltr = PAIR_TEXT[2*(code-1)+k];
			if ($urandom_range(0, 1) == 1) ltr = ltr + 8'd32;
			grp.push_back(ltr);
		end
	endfunction

	function automatic void add_sign();
		case ($urandom_range(0, 2))
			0: grp.push_back(CH_PLUS);
			1: grp.push_back(CH_MINUS);
			default: ;
		endcase
	endfunction

	function automatic void build_random_group();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 5) begin
			// Pure noise bytes.
			repeat ($urandom_range(1, 8)) grp.push_back(8'($urandom_range(0, 255)));
			return;
		end
		add_sign();
		if (kind < 70) n = $urandom_range(0, MAX_CONDS);
		else if (kind < 80) n = MAX_CONDS + $urandom_range(1, 2);
		else n = $urandom_range(0, MAX_CONDS - 1);
		if (n == 0 && grp.size() == 0) n = 1;
		for (int i = 0; i < n; i++) add_code($urandom_range(1, NUM_CODES));
		if (kind >= 80 && kind < 88) begin
			grp.push_back(8'($urandom_range("A", "Z")));
		end else if (kind >= 88) begin
			grp.push_back(8'($urandom_range("A", "Z")));
			grp.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 3)) add_code($urandom_range(1, NUM_CODES));
		end
	endfunction

	initial begin
		arst_n        = 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.ch    <= 8'h00;
		text_ch.last  <= 1'b0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		drained       = 1'b0;
		holds_done    = 0;
		quiet_cycles  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed groups: sign alone, lone letter, lower case, late sign, overflow, raw bytes.
		add_text("+");
		send_group(1'b0);
		add_text("X");
		send_group(1'b0);
		add_text("-tsra");
		send_group(1'b1);
		add_text("RA+SRA");
		send_group(1'b1);
		for (int i = 1; i <= MAX_CONDS + 1; i++) add_code(i);
		send_group(1'b0);
		grp.push_back(8'h00);
		grp.push_back(8'hFF);
		send_group(1'b0);
		wait_all_reports();

		while (board.chars_seen < CHAR_TARGET) begin
			if (board.chars_seen > CHAR_TARGET * 85 / 100) calm = 1'b1;
			if (holds_done == 0 && !hold_req && board.chars_seen > CHAR_TARGET / 4)
				hold_req = 1'b1;
			build_random_group();
			send_group($urandom_range(0, 2) != 0);
			// Once, let every owed report come back before going on.
			if (!drained && board.chars_seen > CHAR_TARGET * 6 / 10) begin
				wait_all_reports();
				drained = 1'b1;
			end
		end

		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.owed() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d characters and %0d reports, %0d mismatches.",
			board.chars_seen, board.reports_checked, board.mismatches);
		$display("Reports by status: ok %0d, dangling %0d, unknown %0d, too many %0d.",
			board.status_seen[ST_OK], board.status_seen[ST_DANGLING],
			board.status_seen[ST_UNKNOWN], board.status_seen[ST_TOO_MANY]);
		if (board.mismatches == 0 && board.owed() == 0) begin
			$display("[weather_condition_code_parser_top] OK");
		end else begin
			$display("[weather_condition_code_parser_top] ERROR");
		end
		$finish;
	end

endmodule
